>>> rtl/pwlc_pkg.sv
`default_nettype none
package pwlc_pkg;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned STATUS_W = 3;

    localparam logic [KIND_W-1:0] KIND_CONVERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERWRITE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EQUAL_X    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAN   = 3'd5;

    // Width of the pool bookkeeping sums: point count up to 255 plus an index up to 1024
    localparam int unsigned SUM_W = 12;

    // Magnitude bits of a divide dividend, and of the divisor
    localparam int unsigned DIVN_W = 65;
    localparam int unsigned DIVD_W = 33;

endpackage
`default_nettype wire

>>> rtl/piecewise_linear_calibrator.sv
`default_nettype none
// Piecewise-linear calibrator, Q16.16, one word at a time. Raise start with a word while busy
// is low; exactly one result follows, shown on value and status for the single cycle that done
// is high, and it cannot be held off, so capture it then. After reset a clearing pass zeroes the
// segment store, one entry a cycle, with busy high. A conversion scans the channel's segments one
// at a time through the store's one read port (read, then compare), then multiplies and adds.
// Reservations and pass-through conversions finish in the decode state. Setting a segment runs
// two 65-step serial divides on a shared restoring divider after two shared multiplies.
module piecewise_linear_calibrator #(
    parameter int unsigned CHANNELS   = 16,
    parameter int unsigned SEGMENTS   = 64,
    parameter int unsigned POOL_LIMIT = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire  [1:0]          kind,
    input  wire  [3:0]          channel,
    input  wire  [7:0]          point_count,
    input  wire  [5:0]          segment_number,
    input  wire  signed [31:0]  x_first,
    input  wire  signed [31:0]  y_first,
    input  wire  signed [31:0]  x_second,
    input  wire  signed [31:0]  y_second,
    input  wire  signed [31:0]  sample,
    output logic                done,
    output logic signed [31:0]  value,
    output logic [2:0]          status
);

    localparam int unsigned SW  = $clog2(SEGMENTS);
    localparam int unsigned NW  = $clog2(SEGMENTS + 1);
    localparam int unsigned CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned SUMW = pwlc_pkg::SUM_W;
    localparam int unsigned NMW  = pwlc_pkg::DIVN_W;
    localparam int unsigned DMW  = pwlc_pkg::DIVD_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CMP, S_MUL, S_ACC,
        S_MUL1, S_MUL2, S_MUL3, S_DIV_INIT, S_DIV, S_DIV_END, S_WRITE
    } state_t;

    state_t state_reg;

    logic [1:0]         kind_reg;
    logic [3:0]         ch_reg;
    logic [7:0]         pts_reg;
    logic [5:0]         seg_reg;
    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg, sample_reg;

    logic [7:0]    cnt_reg  [CHANNELS];
    logic [SW-1:0] base_reg [CHANNELS];
    logic [NW-1:0] nf_reg;

    logic [SW-1:0] idx_reg;
    logic [7:0]    i_reg;

    logic signed [31:0] mul_a_reg, mul_b_reg, offset_reg, slope_reg;
    logic signed [63:0] prod_reg, p1_reg;
    logic signed [NMW-1:0] num_reg, div_num_reg;
    logic [NMW-1:0] dq_reg;
    logic [DMW-1:0] rem_reg;
    logic [6:0]     div_cnt_reg;
    logic           neg_reg, div_sel_reg;

    logic                done_reg;
    logic signed [31:0]  value_reg;
    logic [2:0]          status_reg;

    // segment store: {breakpoint, offset, slope}
    logic [95:0] mem [SEGMENTS];
    logic [95:0] rdata_reg;
    logic        we;
    logic [95:0] wdata;

    logic [CHW-1:0] ch_idx;
    logic [7:0]     ch_cnt;
    logic [SW-1:0]  ch_base;
    logic           ch_bad;
    logic [SUMW-1:0] sum_pool, sum_seg;
    logic signed [DMW-1:0] den;
    logic [DMW-1:0]  den_mag;
    logic [DMW:0]    trial;
    logic            trial_ok;
    logic signed [31:0] q_sat;
    logic signed [48:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic signed [32:0] dy;

    assign ch_idx  = CHW'(ch_reg);
    assign ch_cnt  = cnt_reg[ch_idx];
    assign ch_base = base_reg[ch_idx];
    assign ch_bad  = {5'd0, ch_reg} >= 9'(CHANNELS);
    assign sum_pool = {4'd0, pts_reg} + SUMW'(nf_reg);
    assign sum_seg  = {4'd0, pts_reg} - SUMW'(1) + SUMW'(nf_reg);

    assign den     = DMW'(x2_reg) - DMW'(x1_reg);
    assign den_mag = den[DMW-1] ? DMW'(-den) : DMW'(den);
    assign trial    = {rem_reg, dq_reg[NMW-1]} - {1'b0, den_mag};
    assign trial_ok = {rem_reg, dq_reg[NMW-1]} >= {1'b0, den_mag};
    assign dy = 33'(y2_reg) - 33'(y1_reg);

    always_comb
    begin
        // saturate the signed quotient from its magnitude
        if (neg_reg)
            q_sat = (dq_reg > NMW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                     : 32'(-dq_reg);
        else
            q_sat = (dq_reg > NMW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(dq_reg);
    end

    always_comb
    begin
        acc_sum = 49'(prod_reg >>> 16) + 49'(offset_reg);
        if (acc_sum > 49'sh0_7FFF_FFFF)
            acc_sat = 32'sh7FFF_FFFF;
        else if (acc_sum < -49'sh0_8000_0000)
            acc_sat = 32'sh8000_0000;
        else
            acc_sat = acc_sum[31:0];
    end

    assign we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign wdata = (state_reg == S_CLEAR) ? 96'd0 : {x2_reg, offset_reg, slope_reg};

    always_ff @(posedge clk)
    begin
        if (we)
            mem[idx_reg] <= wdata;
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            idx_reg    <= '0;
            nf_reg     <= '0;
            done_reg   <= 1'b0;
            value_reg  <= '0;
            status_reg <= pwlc_pkg::ST_OK;
            for (int c = 0; c < CHANNELS; c++)
            begin
                cnt_reg[c]  <= '0;
                base_reg[c] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            prod_reg <= mul_a_reg * mul_b_reg;
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (idx_reg == SW'(SEGMENTS - 1))
                        state_reg <= S_IDLE;
                    else
                        idx_reg <= idx_reg + SW'(1);
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg   <= kind;
                        ch_reg     <= channel;
                        pts_reg    <= point_count;
                        seg_reg    <= segment_number;
                        x1_reg     <= x_first;
                        y1_reg     <= y_first;
                        x2_reg     <= x_second;
                        y2_reg     <= y_second;
                        sample_reg <= sample;
                        state_reg  <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    value_reg  <= '0;
                    status_reg <= pwlc_pkg::ST_OK;
                    state_reg  <= S_IDLE;
                    done_reg   <= 1'b1;
                    if (ch_bad)
                        status_reg <= pwlc_pkg::ST_BAD_CHAN;
                    else if (kind_reg == pwlc_pkg::KIND_CONVERT)
                    begin
                        if (ch_cnt == 8'd0)
                            value_reg <= sample_reg;
                        else
                        begin
                            done_reg  <= 1'b0;
                            idx_reg   <= ch_base;
                            i_reg     <= '0;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                    else if (kind_reg == pwlc_pkg::KIND_RESERVE)
                    begin
                        if (pts_reg < 8'd2)
                            status_reg <= pwlc_pkg::ST_BAD_COUNT;
                        else if (ch_cnt == 8'd0)
                        begin
                            if (sum_pool > SUMW'(POOL_LIMIT) || sum_seg > SUMW'(SEGMENTS))
                                status_reg <= pwlc_pkg::ST_POOL_FULL;
                            else
                            begin
                                cnt_reg[ch_idx]  <= pts_reg - 8'd1;
                                base_reg[ch_idx] <= SW'(nf_reg);
                                nf_reg <= nf_reg + NW'(pts_reg - 8'd1);
                            end
                        end
                        else if (ch_cnt != pts_reg - 8'd1)
                            status_reg <= pwlc_pkg::ST_OVERWRITE;
                    end
                    else if (kind_reg == pwlc_pkg::KIND_SET)
                    begin
                        if ({2'd0, seg_reg} >= ch_cnt)
                            status_reg <= pwlc_pkg::ST_OVERWRITE;
                        else if (x1_reg == x2_reg)
                            status_reg <= pwlc_pkg::ST_EQUAL_X;
                        else
                        begin
                            done_reg  <= 1'b0;
                            idx_reg   <= ch_base + SW'(seg_reg);
                            mul_a_reg <= y1_reg;
                            mul_b_reg <= x2_reg;
                            state_reg <= S_MUL1;
                        end
                    end
                end
                S_SCAN_RD:
                    state_reg <= S_SCAN_CMP;
                S_SCAN_CMP:
                begin
                    // first breakpoint at or above the sample, else the last segment
                    if (sample_reg <= $signed(rdata_reg[95:64]) || i_reg == ch_cnt - 8'd1)
                    begin
                        mul_a_reg  <= rdata_reg[31:0];
                        mul_b_reg  <= sample_reg;
                        offset_reg <= rdata_reg[63:32];
                        state_reg  <= S_MUL;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + SW'(1);
                        i_reg     <= i_reg + 8'd1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_MUL:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    value_reg <= acc_sat;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_MUL1:
                begin
                    mul_a_reg <= y2_reg;
                    mul_b_reg <= x1_reg;
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    p1_reg    <= prod_reg;
                    state_reg <= S_MUL3;
                end
                S_MUL3:
                begin
                    num_reg     <= NMW'(p1_reg) - NMW'(prod_reg);
                    // slope over (x2 - x1) uses (y2 - y1) scaled by 2^16
                    div_num_reg <= NMW'($signed({dy, 16'd0}));
                    div_sel_reg <= 1'b0;
                    state_reg   <= S_DIV_INIT;
                end
                S_DIV_INIT:
                begin
                    dq_reg      <= div_num_reg[NMW-1] ? NMW'(-div_num_reg) : NMW'(div_num_reg);
                    rem_reg     <= '0;
                    neg_reg     <= div_num_reg[NMW-1] ^ den[DMW-1];
                    div_cnt_reg <= 7'(NMW);
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    if (trial_ok)
                        rem_reg <= trial[DMW-1:0];
                    else
                        rem_reg <= {rem_reg[DMW-2:0], dq_reg[NMW-1]};
                    dq_reg      <= {dq_reg[NMW-2:0], trial_ok};
                    div_cnt_reg <= div_cnt_reg - 7'd1;
                    if (div_cnt_reg == 7'd1)
                        state_reg <= S_DIV_END;
                end
                S_DIV_END:
                begin
                    if (!div_sel_reg)
                    begin
                        slope_reg   <= q_sat;
                        div_num_reg <= num_reg;
                        div_sel_reg <= 1'b1;
                        state_reg   <= S_DIV_INIT;
                    end
                    else
                    begin
                        offset_reg <= q_sat;
                        state_reg  <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign value  = value_reg;
    assign status = status_reg;

endmodule
`default_nettype wire

>>> dv/calibration_checker.sv
module calibration_checker
    import pwlc_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire                busy,
    input  wire  [1:0]         kind,
    input  wire  [3:0]         channel,
    input  wire  [7:0]         point_count,
    input  wire  [5:0]         segment_number,
    input  wire  signed [31:0] x_first,
    input  wire  signed [31:0] y_first,
    input  wire  signed [31:0] x_second,
    input  wire  signed [31:0] y_second,
    input  wire  signed [31:0] sample,
    input  wire                done,
    input  wire  signed [31:0] value,
    input  wire  [2:0]         status,
    output int                 fails,
    output int                 pending,
    output int                 results_seen
);

    localparam int NUM_CH   = 16;
    localparam int NUM_SEG  = 64;
    localparam int POOL_MAX = 64;

    typedef struct packed {
        logic signed [31:0]   value;
        logic [STATUS_W-1:0]  status;
    } cal_result_t;

    cal_result_t expected_results[$];

    int unsigned        seg_count [NUM_CH];
    int unsigned        seg_base  [NUM_CH];
    int unsigned        free_index;
    logic signed [31:0] seg_slope  [NUM_SEG];
    logic signed [31:0] seg_offset [NUM_SEG];
    logic signed [31:0] seg_limit  [NUM_SEG];

    initial
    begin
        fails = 0;
        results_seen = 0;
        free_index = 0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            seg_count[i] = 0;
            seg_base[i] = 0;
        end
        for (int i = 0; i < NUM_SEG; i++)
        begin
            seg_slope[i] = '0;
            seg_offset[i] = '0;
            seg_limit[i] = '0;
        end
    end

    assign pending = expected_results.size();

    function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -66'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic cal_result_t calibrate(logic [1:0] k, logic [3:0] ch,
                                              logic [7:0] pts, logic [5:0] seg,
                                              logic signed [31:0] xa,
                                              logic signed [31:0] ya,
                                              logic signed [31:0] xb,
                                              logic signed [31:0] yb,
                                              logic signed [31:0] smp);
        cal_result_t        r;
        int unsigned        pick;
        int unsigned        idx;
        bit                 found;
        longint             prod;
        logic signed [65:0] acc;
        logic signed [65:0] x1, y1, x2, y2;
        r.value = '0;
        r.status = ST_OK;
        x1 = xa;
        y1 = ya;
        x2 = xb;
        y2 = yb;
        case (k)
            KIND_CONVERT:
            begin
                if (seg_count[ch] == 0)
                    r.value = smp;
                else
                begin
                    pick = seg_base[ch] + seg_count[ch] - 1;
                    found = 0;
                    for (int i = 0; i < seg_count[ch]; i++)
                    begin
                        if (!found && smp <= seg_limit[seg_base[ch] + i])
                        begin
                            pick = seg_base[ch] + i;
                            found = 1;
                        end
                    end
                    prod = longint'(seg_slope[pick]) * longint'(smp);
                    acc = prod >>> 16;
                    acc = acc + seg_offset[pick];
                    r.value = clamp32(acc);
                end
            end
            KIND_RESERVE:
            begin
                if (pts < 2)
                    r.status = ST_BAD_COUNT;
                else if (seg_count[ch] == 0)
                begin
                    if (pts + free_index > POOL_MAX || pts - 1 + free_index > NUM_SEG)
                        r.status = ST_POOL_FULL;
                    else
                    begin
                        seg_count[ch] = pts - 1;
                        seg_base[ch] = free_index;
                        free_index += pts - 1;
                    end
                end
                else if (seg_count[ch] != pts - 1)
                    r.status = ST_OVERWRITE;
            end
            KIND_SET:
            begin
                idx = seg_base[ch] + seg;
                if (seg >= seg_count[ch] || idx >= NUM_SEG)
                    r.status = ST_OVERWRITE;
                else if (x1 == x2)
                    r.status = ST_EQUAL_X;
                else
                begin
                    seg_slope[idx] = clamp32(((y1 - y2) * 66'sd65536) / (x1 - x2));
                    seg_offset[idx] = clamp32((y1 * x2 - y2 * x1) / (x2 - x1));
                    seg_limit[idx] = xb;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, logic signed [31:0] want, logic signed [31:0] got);
        $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, want, got);
        fails++;
    endtask

    always @(posedge clk)
    begin
        cal_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report("unexpected word", 0, value);
            else
            begin
                want = expected_results.pop_front();
                if (value !== want.value)
                    report("value", want.value, value);
                if (status !== want.status)
                    report("status", want.status, status);
            end
        end
        if (rst_n && start && !busy)
            expected_results.push_back(calibrate(kind, channel, point_count, segment_number,
                                                 x_first, y_first, x_second, y_second,
                                                 sample));
    end

endmodule

>>> dv/tb_top.sv
module tb_top;
    import pwlc_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic [3:0]         channel;
    logic [7:0]         point_count;
    logic [5:0]         segment_number;
    logic signed [31:0] x_first, y_first, x_second, y_second, sample;
    logic               done;
    logic signed [31:0] value;
    logic [2:0]         status;
    int                 fails, pending, results_seen;
    int                 words_sent;
    int                 stall_cycles;

    // mirror of the reservations, to steer stimulus towards live segments
    int unsigned        owned [16];
    int unsigned        pool_next;
    logic signed [31:0] last_break;

    piecewise_linear_calibrator u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .channel(channel), .point_count(point_count), .segment_number(segment_number),
        .x_first(x_first), .y_first(y_first), .x_second(x_second), .y_second(y_second),
        .sample(sample), .done(done), .value(value), .status(status)
    );

    calibration_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .channel(channel), .point_count(point_count), .segment_number(segment_number),
        .x_first(x_first), .y_first(y_first), .x_second(x_second), .y_second(y_second),
        .sample(sample), .done(done), .value(value), .status(status),
        .fails(fails), .pending(pending), .results_seen(results_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_q16();
        case ($urandom_range(0, 7))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2: return 0;
            3, 4: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
            default: return $urandom;
        endcase
    endfunction

    // drive one word and hold it until the block takes it
    task automatic issue(logic [1:0] k, logic [3:0] ch, logic [7:0] pts, logic [5:0] seg,
                         logic signed [31:0] xa, logic signed [31:0] ya,
                         logic signed [31:0] xb, logic signed [31:0] yb,
                         logic signed [31:0] smp);
        start <= 1'b1;
        kind <= k;
        channel <= ch;
        point_count <= pts;
        segment_number <= seg;
        x_first <= xa;
        y_first <= ya;
        x_second <= xb;
        y_second <= yb;
        sample <= smp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (k == KIND_RESERVE && pts >= 2 && owned[ch] == 0 && pts + pool_next <= 64)
        begin
            owned[ch] = pts - 1;
            pool_next += pts - 1;
        end
        if (k == KIND_SET)
            last_break = xb;
    endtask

    task automatic pause(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic random_gap();
        int g;
        g = $urandom_range(0, 9);
        if (g < 6)
            pause(0);
        else if (g < 9)
            pause($urandom_range(1, 3));
        else
            pause($urandom_range(10, 60));
    endtask

    task automatic convert(logic [3:0] ch, logic signed [31:0] smp);
        issue(KIND_CONVERT, ch, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, smp);
    endtask

    task automatic reserve(logic [3:0] ch, logic [7:0] pts);
        issue(KIND_RESERVE, ch, pts, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
    endtask

    task automatic set_segment(logic [3:0] ch, logic [5:0] seg, logic signed [31:0] xa,
                               logic signed [31:0] ya, logic signed [31:0] xb,
                               logic signed [31:0] yb);
        issue(KIND_SET, ch, $urandom, seg, xa, ya, xb, yb, $urandom);
    endtask

    initial
    begin
        int r;
        logic [3:0] ch;
        logic signed [31:0] xa;
        logic signed [31:0] smp;
        words_sent = 0;
        pool_next = 0;
        last_break = 0;
        for (int i = 0; i < 16; i++)
            owned[i] = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        kind <= '0;
        channel <= '0;
        point_count <= '0;
        segment_number <= '0;
        x_first <= '0;
        y_first <= '0;
        x_second <= '0;
        y_second <= '0;
        sample <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // uncalibrated channel passes through
        convert(0, 32'sh7FFFFFFF);
        convert(0, 32'sh80000000);
        reserve(3, 0);
        reserve(3, 1);
        reserve(3, 255);
        reserve(0, 4);
        reserve(0, 4);
        reserve(0, 5);
        set_segment(0, 5, 0, 0, 32'sh10000, 32'sh10000);
        set_segment(1, 0, 0, 0, 32'sh10000, 32'sh10000);
        set_segment(0, 0, 32'sh10000, 5, 32'sh10000, 9);
        set_segment(0, 0, -32'sh10000, -32'sh20000, 32'sh10000, 32'sh20000);
        set_segment(0, 1, 32'sh10000, 32'sh20000, 32'sh50000, -32'sh30000);
        // segment spanning the full Q16.16 range, falling with a slope of -1.0
        set_segment(0, 2, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
        convert(0, -32'sh30000);
        convert(0, 32'sh10000);
        convert(0, 32'sh30000);
        convert(0, 32'sh60000);
        convert(0, 32'sh7FFFFFFF);
        convert(0, 32'sh80000000);
        set_segment(0, 2, 0, 32'sh80000000, 1, 32'sh7FFFFFFF);
        convert(0, 32'sh60000);
        convert(0, 32'sh80000000);
        issue(KIND_UNUSED, 4'hF, 8'hFF, 6'h3F, '1, '1, '1, '1, '1);
        reserve(1, 2);

        for (int n = 0; n < 800; n++)
        begin
            if (n == 400)
            begin
                pause(1);
                while (pending != 0)
                    @(posedge clk);
            end
            random_gap();
            r = $urandom_range(0, 99);
            ch = $urandom;
            if (r < 50)
            begin
                smp = ($urandom_range(0, 2) == 0)
                      ? last_break + $signed($urandom_range(0, 2)) - 1 : pick_q16();
                convert(ch, smp);
            end
            else if (r < 80)
            begin
                xa = pick_q16();
                set_segment(ch,
                            (owned[ch] > 0 && $urandom_range(0, 9) > 0)
                              ? 6'($urandom_range(0, owned[ch] - 1)) : 6'($urandom),
                            xa, pick_q16(),
                            ($urandom_range(0, 19) == 0) ? xa : pick_q16(), pick_q16());
            end
            else if (r < 95)
                reserve(ch, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(2, 6)));
            else
                issue(KIND_UNUSED, ch, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        end
        pause(1);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d words through convert, reserve and set, %0d results checked,",
                 words_sent, results_seen);
        $display("with %0d of 64 pool segments reserved by the end.", pool_next);
        if (fails == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pwlc_pkg.sv
rtl/piecewise_linear_calibrator.sv
dv/calibration_checker.sv
dv/tb_top.sv
